[hw/rtl/stsg_pkg.sv]
package stsg_pkg;

	// Field widths.
	localparam int RATE_W  = 18;
	localparam int CHCNT_W = 4;
	localparam int BYTES_W = 3;
	localparam int HZ_W    = 16;
	localparam int SAMPLE_W = 32;
	localparam int CHIDX_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 18;
	localparam int PHASE_W = 32;

	// Register reset values.
	localparam logic [RATE_W-1:0]  SAMPLE_RATE_RST   = RATE_W'(48000);
	localparam logic [CHCNT_W-1:0] CHANNEL_COUNT_RST = CHCNT_W'(2);
	localparam logic [BYTES_W-1:0] SAMPLE_BYTES_RST  = BYTES_W'(2);

	localparam int MAX_CHANNELS = 8;

	// Register indexes on the configuration channel.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAMPLE_RATE   = 2'd0,
		CFG_CHANNEL_COUNT = 2'd1,
		CFG_SAMPLE_BYTES  = 2'd2
	} cfg_idx_t;

	// Serial divider: DIGIT quotient bits per cycle.
	localparam int DIGIT = 2;
	localparam int DIV_STEPS_PERIOD = RATE_W / DIGIT;
	localparam int DIV_STEPS_PHASE = (RATE_W + PHASE_W) / DIGIT;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS_PHASE);

	// CORDIC datapath.
	localparam int TURN_TABLE_LEN = 24;
	localparam int ANGLE_ITERATIONS = 16;
	localparam int ITER_W = $clog2(TURN_TABLE_LEN);
	localparam int CW = 34;
	localparam logic [CW-1:0] CORDIC_X0 = CW'(652032874);
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;

	// Serial scaler: amplitude is under 2^30, shifted out DIGIT bits per cycle.
	localparam int AMP_W = 30;
	localparam int SCALE_STEPS = AMP_W / DIGIT;
	localparam int SCL_CNT_W = $clog2(SCALE_STEPS);

	// Handshake status of a multi-cycle unit.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	// Clamp the byte count to 1..4 and return it less one.
	function automatic logic [1:0] byte_code(input logic [BYTES_W-1:0] b);
		logic [1:0] r;
		if (b == BYTES_W'(0)) begin
			r = 2'd0;
		end else if (b > BYTES_W'(4)) begin
			r = 2'd3;
		end else begin
			r = 2'(b - BYTES_W'(1));
		end
		return r;
	endfunction

	// One fifth of full scale for each sample size.
	function automatic logic [AMP_W-1:0] amp_for(input logic [1:0] code);
		logic [AMP_W-1:0] r;
		case (code)
			2'd0:    r = AMP_W'(25);
			2'd1:    r = AMP_W'(6553);
			2'd2:    r = AMP_W'(1677721);
			default: r = AMP_W'(429496729);
		endcase
		return r;
	endfunction

	// Index of the last channel, with the count clamped to 1..MAX_CHANNELS.
	function automatic logic [CHIDX_W-1:0] last_channel(input logic [CHCNT_W-1:0] n);
		logic [CHIDX_W-1:0] r;
		if (n == CHCNT_W'(0)) begin
			r = '0;
		end else if (n >= CHCNT_W'(MAX_CHANNELS)) begin
			r = CHIDX_W'(MAX_CHANNELS - 1);
		end else begin
			r = CHIDX_W'(n - CHCNT_W'(1));
		end
		return r;
	endfunction

endpackage

[hw/rtl/stsg_ifs.sv]
// Tone request channel.
interface stsg_tone_if;
	logic                          valid;
	logic                          ready;
	logic [stsg_pkg::HZ_W-1:0]     tone_hz;
	logic                          final_frame;

	modport source (output valid, tone_hz, final_frame, input ready);
	modport sink (input valid, tone_hz, final_frame, output ready);
endinterface

// Sample result channel.
interface stsg_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [stsg_pkg::SAMPLE_W-1:0] sample_value;
	logic [stsg_pkg::CHIDX_W-1:0]         channel_index;
	logic                                 frame_last;
	logic                                 buffer_last;

	modport source (output valid, sample_value, channel_index, frame_last, buffer_last,
		input ready);
	modport sink (input valid, sample_value, channel_index, frame_last, buffer_last,
		output ready);
endinterface

// Register write channel.
interface stsg_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [stsg_pkg::CFG_IDX_W-1:0]    index;
	logic [stsg_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/stsg_div.sv]
// Restoring divider, DIGIT quotient bits per cycle. The dividend is num
// followed by zeros; the low 32 quotient bits are kept.
module stsg_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [stsg_pkg::RATE_W-1:0]        num,
	input  logic [stsg_pkg::RATE_W-1:0]        den,
	input  logic [stsg_pkg::DIV_CNT_W-1:0]     steps,
	output stsg_pkg::unit_stat_t               stat,
	output logic [stsg_pkg::PHASE_W-1:0]       quot
);

	logic                              busy_q;
	logic                              done_q;
	logic [stsg_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [stsg_pkg::DIV_CNT_W-1:0]    last_q;
	logic [stsg_pkg::RATE_W-1:0]       num_q;
	logic [stsg_pkg::RATE_W-1:0]       den_q;
	logic [stsg_pkg::RATE_W-1:0]       rem_q;
	logic [stsg_pkg::PHASE_W-1:0]      quot_q;

	logic [stsg_pkg::RATE_W-1:0]       rem_v;
	logic [stsg_pkg::RATE_W-1:0]       num_v;
	logic [stsg_pkg::PHASE_W-1:0]      quot_v;
	logic [stsg_pkg::RATE_W:0]         trial;
	logic [stsg_pkg::RATE_W+1:0]       diff;

	// One digit of restoring division: shift in a dividend bit, subtract if it fits.
	always_comb begin
		rem_v = rem_q;
		num_v = num_q;
		quot_v = quot_q;
		trial = '0;
		diff = '0;
		for (int k = 0; k < stsg_pkg::DIGIT; k++) begin
			trial = {rem_v, num_v[stsg_pkg::RATE_W-1]};
			diff = {1'b0, trial} - {2'b00, den_q};
			if (!diff[stsg_pkg::RATE_W+1]) begin
				rem_v = diff[stsg_pkg::RATE_W-1:0];
			end else begin
				rem_v = trial[stsg_pkg::RATE_W-1:0];
			end
			num_v = {num_v[stsg_pkg::RATE_W-2:0], 1'b0};
			quot_v = {quot_v[stsg_pkg::PHASE_W-2:0], ~diff[stsg_pkg::RATE_W+1]};
		end
	end

	// Sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + stsg_pkg::DIV_CNT_W'(1);
				if (cnt_q == last_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quot_q <= '0;
			last_q <= steps - stsg_pkg::DIV_CNT_W'(1);
		end else if (busy_q) begin
			num_q <= num_v;
			rem_q <= rem_v;
			quot_q <= quot_v;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot = quot_q;

endmodule

[hw/rtl/stsg_cordic.sv]
// Rotation-mode CORDIC, one iteration per cycle, angles in 2^-32 turn.
module stsg_cordic (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [stsg_pkg::PHASE_W-1:0]   phase,
	output stsg_pkg::unit_stat_t           stat,
	output logic signed [stsg_pkg::CW-1:0] sine
);

	logic                           busy_q;
	logic                           done_q;
	logic [stsg_pkg::ITER_W-1:0]    i_q;
	logic signed [stsg_pkg::CW-1:0] x_q;
	logic signed [stsg_pkg::CW-1:0] y_q;
	logic signed [stsg_pkg::CW-1:0] z_q;

	logic [stsg_pkg::PHASE_W-1:0]   th;
	logic signed [stsg_pkg::CW-1:0] z0;
	logic signed [stsg_pkg::CW-1:0] xs;
	logic signed [stsg_pkg::CW-1:0] ys;
	logic signed [stsg_pkg::CW-1:0] at;

	// Fold the back half-turn onto the front so the angle lies within a quarter turn.
	always_comb begin
		th = phase;
		if (phase > 32'h4000_0000 && phase < 32'hC000_0000) begin
			th = 32'h8000_0000 - phase;
		end
		z0 = $signed({{(stsg_pkg::CW-stsg_pkg::PHASE_W){th[stsg_pkg::PHASE_W-1]}}, th});
	end

	// Shifted terms for the current iteration.
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = $signed({{(stsg_pkg::CW-32){1'b0}}, stsg_pkg::atan_turn(i_q)});

	// Sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				i_q <= i_q + stsg_pkg::ITER_W'(1);
				if (i_q == stsg_pkg::ITER_W'(stsg_pkg::ANGLE_ITERATIONS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Micro-rotations toward zero residual angle.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= $signed(stsg_pkg::CORDIC_X0);
			y_q <= '0;
			z_q <= z0;
		end else if (busy_q) begin
			if (z_q[stsg_pkg::CW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign sine = y_q;

endmodule

[hw/rtl/stsg_scale.sv]
// Sign-magnitude scaler: |sine| (saturated to one) times the amplitude,
// shift-and-add over the amplitude bits, LSB first, then floor by 2^30.
module stsg_scale (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [stsg_pkg::CW-1:0]        sine,
	input  logic [1:0]                            bytes_code,
	output stsg_pkg::unit_stat_t                  stat,
	output logic signed [stsg_pkg::SAMPLE_W-1:0]  sample
);

	logic                              busy_q;
	logic                              done_q;
	logic [stsg_pkg::SCL_CNT_W-1:0]    cnt_q;
	logic                              neg_q;
	logic [30:0]                       mag_q;
	logic [stsg_pkg::AMP_W-1:0]        amp_q;
	logic [stsg_pkg::SAMPLE_W-1:0]     acc_q;

	logic [stsg_pkg::CW-1:0]           mag_full;
	logic [30:0]                       mag_sat;
	logic [stsg_pkg::SAMPLE_W-1:0]     acc_v;
	logic [stsg_pkg::SAMPLE_W-1:0]     sum_v;
	logic [stsg_pkg::AMP_W-1:0]        amp_v;

	// Magnitude of the sine, clipped at one in Q30.
	always_comb begin
		if (sine[stsg_pkg::CW-1]) begin
			mag_full = stsg_pkg::CW'(0) - sine;
		end else begin
			mag_full = sine;
		end
		if (mag_full > stsg_pkg::CW'(stsg_pkg::Q30_ONE)) begin
			mag_sat = stsg_pkg::Q30_ONE;
		end else begin
			mag_sat = mag_full[30:0];
		end
	end

	// One digit of the product; the bits shifted out are below the result.
	always_comb begin
		acc_v = acc_q;
		amp_v = amp_q;
		sum_v = '0;
		for (int k = 0; k < stsg_pkg::DIGIT; k++) begin
			sum_v = acc_v + (amp_v[0] ? {1'b0, mag_q} : stsg_pkg::SAMPLE_W'(0));
			acc_v = {1'b0, sum_v[stsg_pkg::SAMPLE_W-1:1]};
			amp_v = {1'b0, amp_v[stsg_pkg::AMP_W-1:1]};
		end
	end

	// Sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + stsg_pkg::SCL_CNT_W'(1);
				if (cnt_q == stsg_pkg::SCL_CNT_W'(stsg_pkg::SCALE_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= sine[stsg_pkg::CW-1];
			mag_q <= mag_sat;
			amp_q <= stsg_pkg::amp_for(bytes_code);
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_v;
			amp_q <= amp_v;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign sample = neg_q ? $signed(stsg_pkg::SAMPLE_W'(0) - acc_q) : $signed(acc_q);

endmodule

[hw/rtl/stsg_emit.sv]
// Output register: repeats one frame's sample once per channel.
module stsg_emit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  logic signed [stsg_pkg::SAMPLE_W-1:0] sample,
	input  logic [stsg_pkg::CHIDX_W-1:0]         last_idx,
	input  logic                                 fin,
	output logic                                 free,
	stsg_sample_if.source                        sample_out
);

	logic                                 active_q;
	logic [stsg_pkg::CHIDX_W-1:0]         idx_q;
	logic [stsg_pkg::CHIDX_W-1:0]         last_q;
	logic                                 fin_q;
	logic signed [stsg_pkg::SAMPLE_W-1:0] sample_q;
	logic                                 taken;
	logic                                 at_last;

	assign taken = active_q && sample_out.ready;
	assign at_last = (idx_q == last_q);

	// Channel counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			active_q <= 1'b1;
			idx_q <= '0;
		end else if (taken) begin
			if (at_last) begin
				active_q <= 1'b0;
			end else begin
				idx_q <= idx_q + stsg_pkg::CHIDX_W'(1);
			end
		end
	end

	// Frame payload.
	always_ff @(posedge clk) begin
		if (load) begin
			sample_q <= sample;
			last_q <= last_idx;
			fin_q <= fin;
		end
	end

	assign free = !active_q;
	assign sample_out.valid = active_q;
	assign sample_out.sample_value = sample_q;
	assign sample_out.channel_index = idx_q;
	assign sample_out.frame_last = at_last;
	assign sample_out.buffer_last = at_last && fin_q;

endmodule

[hw/rtl/sine_tone_sample_generator.sv]
// From an accepted tone request to the first sample: the serial divider works
// out the period and then the phase, the CORDIC rotates, the scaler scales and
// the frame is handed off; a zero tone or a zero period goes straight to handoff.
// Requests are taken one at a time, the divider, CORDIC and scaler running in turn;
// samples leave at one per cycle when the sink is ready, while the next one computes.
// Reset: asynchronous, clears the phase position and restores the registers.
module sine_tone_sample_generator (
	input  logic          clk,
	input  logic          arst_n,
	stsg_tone_if.sink     tone_in,
	stsg_sample_if.source sample_out,
	stsg_cfg_if.sink      cfg
);

	typedef enum logic [5:0] {
		ST_IDLE       = 6'b000001,
		ST_DIV_PERIOD = 6'b000010,
		ST_DIV_PHASE  = 6'b000100,
		ST_CORDIC     = 6'b001000,
		ST_SCALE      = 6'b010000,
		ST_HANDOFF    = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	logic [stsg_pkg::RATE_W-1:0]          sample_rate_q;
	logic [stsg_pkg::CHCNT_W-1:0]         channel_count_q;
	logic [stsg_pkg::BYTES_W-1:0]         sample_bytes_q;
	logic [stsg_pkg::RATE_W-1:0]          pos_q;
	logic [stsg_pkg::RATE_W-1:0]          pos_inc;

	logic [stsg_pkg::RATE_W-1:0]          period_q;
	logic signed [stsg_pkg::SAMPLE_W-1:0] sample_q;
	logic [stsg_pkg::CHIDX_W-1:0]         last_ch_q;
	logic [1:0]                           bytes_code_q;
	logic                                 fin_q;

	logic                                 tone_accept;
	logic                                 cfg_write;
	logic                                 emit_free;
	logic                                 emit_load;

	logic                                 div_start;
	logic [stsg_pkg::RATE_W-1:0]          div_num;
	logic [stsg_pkg::RATE_W-1:0]          div_den;
	logic [stsg_pkg::DIV_CNT_W-1:0]       div_steps;
	logic [stsg_pkg::PHASE_W-1:0]         div_quot;
	stsg_pkg::unit_stat_t                 div_st;

	logic                                 cor_start;
	logic signed [stsg_pkg::CW-1:0]       cor_sine;
	stsg_pkg::unit_stat_t                 cor_st;

	logic                                 scl_start;
	logic signed [stsg_pkg::SAMPLE_W-1:0] scl_sample;
	stsg_pkg::unit_stat_t                 scl_st;

	assign tone_in.ready = (state_q == ST_IDLE);
	assign tone_accept = tone_in.valid && tone_in.ready;
	assign cfg.ready = 1'b1;
	assign cfg_write = cfg.valid && cfg.ready;
	assign emit_load = (state_q == ST_HANDOFF) && emit_free;
	assign pos_inc = pos_q + stsg_pkg::RATE_W'(1);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= stsg_pkg::SAMPLE_RATE_RST;
			channel_count_q <= stsg_pkg::CHANNEL_COUNT_RST;
			sample_bytes_q <= stsg_pkg::SAMPLE_BYTES_RST;
		end else if (cfg_write) begin
			unique case (cfg.index)
				stsg_pkg::CFG_SAMPLE_RATE: begin
					sample_rate_q <= cfg.data[stsg_pkg::RATE_W-1:0];
				end
				stsg_pkg::CFG_CHANNEL_COUNT: begin
					channel_count_q <= cfg.data[stsg_pkg::CHCNT_W-1:0];
				end
				stsg_pkg::CFG_SAMPLE_BYTES: begin
					sample_bytes_q <= cfg.data[stsg_pkg::BYTES_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Sequencer over the shared units.
	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		div_num = sample_rate_q;
		div_den = stsg_pkg::RATE_W'(tone_in.tone_hz);
		div_steps = stsg_pkg::DIV_CNT_W'(stsg_pkg::DIV_STEPS_PERIOD);
		cor_start = 1'b0;
		scl_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (tone_accept) begin
					if (tone_in.tone_hz != stsg_pkg::HZ_W'(0)) begin
						div_start = 1'b1;
						state_d = ST_DIV_PERIOD;
					end else begin
						state_d = ST_HANDOFF;
					end
				end
			end
			ST_DIV_PERIOD: begin
				div_num = pos_q;
				div_den = div_quot[stsg_pkg::RATE_W-1:0];
				div_steps = stsg_pkg::DIV_CNT_W'(stsg_pkg::DIV_STEPS_PHASE);
				if (div_st.done) begin
					if (div_quot[stsg_pkg::RATE_W-1:0] != stsg_pkg::RATE_W'(0)) begin
						div_start = 1'b1;
						state_d = ST_DIV_PHASE;
					end else begin
						state_d = ST_HANDOFF;
					end
				end
			end
			ST_DIV_PHASE: begin
				if (div_st.done) begin
					cor_start = 1'b1;
					state_d = ST_CORDIC;
				end
			end
			ST_CORDIC: begin
				if (cor_st.done) begin
					scl_start = 1'b1;
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				if (scl_st.done) begin
					state_d = ST_HANDOFF;
				end
			end
			ST_HANDOFF: begin
				if (emit_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and phase position; the position wraps once it reaches the period.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
		end else begin
			state_q <= state_d;
			if (emit_load) begin
				if (pos_inc >= period_q) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_inc;
				end
			end
		end
	end

	// Per-request values.
	always_ff @(posedge clk) begin
		if (tone_accept) begin
			fin_q <= tone_in.final_frame;
			last_ch_q <= stsg_pkg::last_channel(channel_count_q);
			bytes_code_q <= stsg_pkg::byte_code(sample_bytes_q);
			period_q <= '0;
			sample_q <= '0;
		end else if (state_q == ST_DIV_PERIOD && div_st.done) begin
			period_q <= div_quot[stsg_pkg::RATE_W-1:0];
		end else if (state_q == ST_SCALE && scl_st.done) begin
			sample_q <= scl_sample;
		end
	end

	stsg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.steps  (div_steps),
		.stat   (div_st),
		.quot   (div_quot)
	);

	stsg_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.phase  (div_quot),
		.stat   (cor_st),
		.sine   (cor_sine)
	);

	stsg_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (scl_start),
		.sine       (cor_sine),
		.bytes_code (bytes_code_q),
		.stat       (scl_st),
		.sample     (scl_sample)
	);

	stsg_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (emit_load),
		.sample     (sample_q),
		.last_idx   (last_ch_q),
		.fin        (fin_q),
		.free       (emit_free),
		.sample_out (sample_out)
	);

`ifndef NO_ASSERTIONS
	// The arithmetic units run strictly one after another.
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({div_st.busy, cor_st.busy, scl_st.busy}))
		else $error("more than one arithmetic unit busy");

	// After a frame is handed off, the position lies inside the period or is zero.
	a_pos_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load |=> (pos_q == '0 || pos_q < period_q))
		else $error("phase position not wrapped");

	// A frame keeps presenting samples until its last channel is taken.
	a_frame_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_out.valid && sample_out.ready && !sample_out.frame_last) |=>
		sample_out.valid)
		else $error("frame ended before its last channel");
`endif

endmodule

[tb/tb_sine_tone_sample_generator.sv]
`timescale 1ns / 100ps

module tb_sine_tone_sample_generator;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES = 100;
	localparam int REPORT_LIMIT = 10;
	localparam int CORDIC_STEPS = 16;
	localparam logic [stsg_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
	localparam logic [63:0] GAIN_Q30 = 64'd652032874;
	localparam logic [63:0] UNIT_Q30 = 64'h4000_0000;

	// Rotation angles atan(2^-i) in units of 2^-32 turn.
	localparam logic [0:CORDIC_STEPS-1][31:0] ARCTAN_TURNS = {
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861
	};

	typedef struct packed {
		logic [stsg_pkg::HZ_W-1:0] hz;
		logic                      fin;
	} tone_req_t;

	typedef struct packed {
		logic signed [stsg_pkg::SAMPLE_W-1:0] value;
		logic [stsg_pkg::CHIDX_W-1:0]         chan;
		logic                                 flast;
		logic                                 blast;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n;

	stsg_tone_if   tone_bus ();
	stsg_sample_if sample_bus ();
	stsg_cfg_if    cfg_bus ();

	sine_tone_sample_generator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.tone_in   (tone_bus),
		.sample_out(sample_bus),
		.cfg       (cfg_bus)
	);

	tone_req_t pending_reqs[$];
	sample_t   expected_samples[$];

	// Shadow copy of the registers and the phase position.
	logic [stsg_pkg::RATE_W-1:0]  rate_reg;
	logic [stsg_pkg::CHCNT_W-1:0] chcnt_reg;
	logic [stsg_pkg::BYTES_W-1:0] bytes_reg;
	logic [stsg_pkg::RATE_W-1:0]  position;

	int send_idle_pct;
	int recv_idle_pct;
	bit drain_hold;
	int accepted_reqs;
	int mismatches;
	int quiet_cycles;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Sine of a turn fraction in Q30, by CORDIC rotation after folding to +-1/4 turn.
	function automatic logic signed [63:0] cordic_sine(input logic [31:0] turn);
		logic [31:0] th;
		logic signed [63:0] x, y, z, nx, ny;
		int i;
		th = turn;
		if (th > 32'h4000_0000 && th < 32'hC000_0000) begin
			th = 32'h8000_0000 - th;
		end
		z = {{32{th[31]}}, th};
		x = GAIN_Q30;
		y = '0;
		for (i = 0; i < CORDIC_STEPS; i++) begin
			if (z[63]) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z = z + ARCTAN_TURNS[i];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z = z - ARCTAN_TURNS[i];
			end
			x = nx;
			y = ny;
		end
		return y;
	endfunction

	// Work out the samples of one frame request and advance the position.
	task automatic predict_frame(input tone_req_t req);
		logic [stsg_pkg::RATE_W-1:0] period;
		logic [31:0] turn;
		logic signed [63:0] s;
		logic [63:0] mag, amp, v;
		logic [stsg_pkg::SAMPLE_W-1:0] value;
		int nch, nbytes, j;
		sample_t smp;
		nch = chcnt_reg;
		if (nch < 1) nch = 1;
		if (nch > stsg_pkg::MAX_CHANNELS) nch = stsg_pkg::MAX_CHANNELS;
		nbytes = bytes_reg;
		if (nbytes < 1) nbytes = 1;
		if (nbytes > 4) nbytes = 4;
		period = (req.hz == '0) ? '0 : stsg_pkg::RATE_W'(rate_reg / req.hz);
		value = '0;
		if (period != '0) begin
			amp = (64'd1 << (nbytes * 8 - 1)) / 5;
			turn = 32'({position, 32'd0} / period);
			s = cordic_sine(turn);
			mag = s[63] ? -s : s;
			if (mag > UNIT_Q30) mag = UNIT_Q30;
			v = (mag * amp) >> 30;
			if (s[63]) v = -v;
			value = v[stsg_pkg::SAMPLE_W-1:0];
		end
		for (j = 0; j < nch; j++) begin
			smp.value = value;
			smp.chan = stsg_pkg::CHIDX_W'(j);
			smp.flast = (j == nch - 1);
			smp.blast = smp.flast & req.fin;
			expected_samples.push_back(smp);
		end
		position = position + 1'b1;
		if (position >= period) position = '0;
	endtask

	// Tone request driver: presents queued requests with random gaps, and now and
	// then holds off until every outstanding sample has come back.
	always @(posedge clk) begin : tone_drive
		logic show;
		if (arst_n) begin
			show = tone_bus.valid;
			if (tone_bus.valid && tone_bus.ready) begin
				predict_frame(pending_reqs.pop_front());
				accepted_reqs++;
				if (accepted_reqs % 37 == 5) drain_hold = 1'b1;
				show = 1'b0;
			end
			if (drain_hold && expected_samples.size() == 0) drain_hold = 1'b0;
			if (!show && !drain_hold && pending_reqs.size() > 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				show = 1'b1;
			end
			if (show) begin
				tone_bus.tone_hz <= pending_reqs[0].hz;
				tone_bus.final_frame <= pending_reqs[0].fin;
			end
			tone_bus.valid <= show;
		end
	end

	// Sample checker: compares each accepted sample with the oldest prediction.
	always @(posedge clk) begin : sample_check
		sample_t want;
		if (arst_n) begin
			if (sample_bus.valid && sample_bus.ready) begin
				if (expected_samples.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("unexpected sample: value %0d ch %0d last %b buf %b",
							sample_bus.sample_value, sample_bus.channel_index,
							sample_bus.frame_last, sample_bus.buffer_last);
					end
				end else begin
					want = expected_samples.pop_front();
					if (sample_bus.sample_value !== want.value ||
							sample_bus.channel_index !== want.chan ||
							sample_bus.frame_last !== want.flast ||
							sample_bus.buffer_last !== want.blast) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display({"sample mismatch: expected value %0d ch %0d ",
								"last %b buf %b, got value %0d ch %0d last %b buf %b"},
								want.value, want.chan, want.flast, want.blast,
								sample_bus.sample_value, sample_bus.channel_index,
								sample_bus.frame_last, sample_bus.buffer_last);
						end
					end
				end
			end
			sample_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: ends the run when no handshake of any kind happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (tone_bus.valid && tone_bus.ready) ||
				(sample_bus.valid && sample_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Register write request; the shadow copy follows once it is accepted.
	task automatic write_reg(input logic [stsg_pkg::CFG_IDX_W-1:0] idx,
			input logic [stsg_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		case (idx)
			stsg_pkg::CFG_SAMPLE_RATE: begin
				rate_reg = value[stsg_pkg::RATE_W-1:0];
			end
			stsg_pkg::CFG_CHANNEL_COUNT: begin
				chcnt_reg = value[stsg_pkg::CHCNT_W-1:0];
			end
			stsg_pkg::CFG_SAMPLE_BYTES: begin
				bytes_reg = value[stsg_pkg::BYTES_W-1:0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic queue_tone(input logic [stsg_pkg::HZ_W-1:0] hz, input logic fin);
		tone_req_t req;
		req.hz = hz;
		req.fin = fin;
		pending_reqs.push_back(req);
	endtask

	// Mostly runs of frames at one tone, so the position walks through the period;
	// the rest are single frames at any frequency, silent ones included.
	task automatic queue_random_tones(input int count);
		logic [31:0] hz_calc;
		int run, k;
		while (count > 0) begin
			if ($urandom_range(9) < 7) begin
				hz_calc = rate_reg / $urandom_range(24, 2);
				if (hz_calc == 0 || hz_calc > 65535) hz_calc = $urandom_range(65535, 1);
				run = $urandom_range(12, 3);
			end else begin
				hz_calc = $urandom_range(65535, 0);
				run = 1;
			end
			for (k = 0; k < run && count > 0; k++) begin
				queue_tone(hz_calc[stsg_pkg::HZ_W-1:0], 1'($urandom_range(1)));
				count--;
			end
		end
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (pending_reqs.size() != 0 || tone_bus.valid || expected_samples.size() != 0);
	endtask

	initial begin
		arst_n = 1'b0;
		tone_bus.valid = 1'b0;
		tone_bus.tone_hz = '0;
		tone_bus.final_frame = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		sample_bus.ready = 1'b0;
		rate_reg = stsg_pkg::SAMPLE_RATE_RST;
		chcnt_reg = stsg_pkg::CHANNEL_COUNT_RST;
		bytes_reg = stsg_pkg::SAMPLE_BYTES_RST;
		position = '0;
		send_idle_pct = 35;
		recv_idle_pct = 51;
		drain_hold = 1'b0;
		accepted_reqs = 0;
		mismatches = 0;
		quiet_cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed frames at the reset settings. Zero frequency and a tone above
		// the sample rate give silence.
		queue_tone(16'd0, 1'b1);
		queue_tone(16'hFFFF, 1'b0);
		queue_tone(16'd1, 1'b0);
		queue_tone(16'd1, 1'b1);
		// A period of four visits every quadrant of the sine.
		repeat (4) queue_tone(16'd12000, 1'b0);
		// Move the position well ahead, then shrink the period below it.
		repeat (6) queue_tone(16'd1000, 1'b1);
		queue_tone(16'd16000, 1'b0);
		queue_tone(16'd48000, 1'b1);
		queue_tone(16'd48001, 1'b1);
		queue_tone(16'hAAAA, 1'b0);
		queue_tone(16'h5555, 1'b1);
		wait_drained();

		// Top of the rate range, full frames of four-byte samples.
		write_reg(stsg_pkg::CFG_SAMPLE_RATE, stsg_pkg::CFG_DATA_W'(192000));
		write_reg(stsg_pkg::CFG_CHANNEL_COUNT, stsg_pkg::CFG_DATA_W'(stsg_pkg::MAX_CHANNELS));
		write_reg(stsg_pkg::CFG_SAMPLE_BYTES, stsg_pkg::CFG_DATA_W'(4));
		queue_random_tones(25);
		wait_drained();

		// Lowest legal settings.
		write_reg(stsg_pkg::CFG_SAMPLE_RATE, stsg_pkg::CFG_DATA_W'(1));
		write_reg(stsg_pkg::CFG_CHANNEL_COUNT, stsg_pkg::CFG_DATA_W'(1));
		write_reg(stsg_pkg::CFG_SAMPLE_BYTES, stsg_pkg::CFG_DATA_W'(1));
		queue_random_tones(25);
		wait_drained();

		send_idle_pct = 51;
		recv_idle_pct = 35;

		// All zero: every frame is silent, counts act as one.
		write_reg(stsg_pkg::CFG_SAMPLE_RATE, '0);
		write_reg(stsg_pkg::CFG_CHANNEL_COUNT, '0);
		write_reg(stsg_pkg::CFG_SAMPLE_BYTES, '0);
		queue_random_tones(15);
		wait_drained();

		// All ones in every field; counts saturate, and an unmapped index is dropped.
		write_reg(stsg_pkg::CFG_SAMPLE_RATE, '1);
		write_reg(stsg_pkg::CFG_CHANNEL_COUNT, '1);
		write_reg(stsg_pkg::CFG_SAMPLE_BYTES, '1);
		write_reg(CFG_UNMAPPED, '1);
		queue_random_tones(25);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;

		write_reg(stsg_pkg::CFG_SAMPLE_RATE, stsg_pkg::CFG_DATA_W'(44100));
		write_reg(stsg_pkg::CFG_CHANNEL_COUNT, stsg_pkg::CFG_DATA_W'(3));
		write_reg(stsg_pkg::CFG_SAMPLE_BYTES, stsg_pkg::CFG_DATA_W'(3));
		queue_random_tones(30);
		wait_drained();

		write_reg(stsg_pkg::CFG_SAMPLE_RATE,
			stsg_pkg::CFG_DATA_W'($urandom_range(192000, 1000)));
		write_reg(stsg_pkg::CFG_CHANNEL_COUNT, stsg_pkg::CFG_DATA_W'($urandom_range(15, 0)));
		write_reg(stsg_pkg::CFG_SAMPLE_BYTES, stsg_pkg::CFG_DATA_W'($urandom_range(7, 0)));
		queue_random_tones(30);
		wait_drained();

		// Let any stray samples show up before the verdict.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
